[rtl/rmsn_pkg.sv]
// rmsn_pkg: shared types, widths and codes for the RMS vector normaliser.
// Used by the channel interfaces and by every RTL module of the block.
`default_nettype none

package rmsn_pkg;

	// field widths
	localparam int SAMPLE_W = 24;
	localparam int GAIN_W   = 16;
	localparam int VALUE_W  = 24;
	localparam int VL_W     = 13;
	localparam int EPS_W    = 32;
	localparam int INV_W    = 32;
	localparam int SUM_W    = 64;

	// configuration port
	localparam int  ADDR_W = 3;
	localparam int  DATA_W = 32;
	localparam logic REG_VL  = 1'b0;
	localparam logic REG_EPS = 1'b1;
	localparam logic [VL_W-1:0]  VL_RESET  = 13'd4096;
	localparam logic [EPS_W-1:0] EPS_RESET = 32'd4295;
	localparam int MAX_LENGTH_DEF = 4096;

	// shared multiplier: 24 x 32 unsigned
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 32;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam logic [1:0] MUL_SQ = 2'd0;	// sample squared
	localparam logic [1:0] MUL_SG = 2'd1;	// |sample| * |gain|
	localparam logic [1:0] MUL_LO = 2'd2;	// low slice of product * inverse
	localparam logic [1:0] MUL_HI = 2'd3;	// high slice of product * inverse

	// scale pass product: |s|*|g| is 39 bits, split at bit 20
	localparam int SG_W       = SAMPLE_W + GAIN_W - 1;
	localparam int LO_W       = 20;
	localparam int HI_W       = SG_W - LO_W;
	localparam int SQ_W       = 2 * SAMPLE_W - 1;
	localparam int ACC_W      = 72;
	localparam int FRAC_SHIFT = 28;
	localparam int MAG_W      = ACC_W - FRAC_SHIFT;
	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);
	localparam logic [VALUE_W-1:0] VALUE_POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] VALUE_NEG_MAG = {1'b1, {(VALUE_W-1){1'b0}}};

	// iterative units
	localparam int DIV_W      = SUM_W + 1;
	localparam int DIV_STEPS  = DIV_W;
	localparam int SQRT_STEPS = INV_W;
	localparam int SQ_REM_W   = INV_W + 2;
	localparam int ITER_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic                       op;
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [GAIN_W-1:0]   gain;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      saturated;
		logic                      last;
	} out_item_t;

	typedef struct packed {
		logic [VL_W-1:0]  vector_length;
		logic [EPS_W-1:0] epsilon;
	} cfg_t;

	typedef struct packed {
		logic       capture;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       hold_hi;
		logic       acc_sq;
		logic       ld_mean;
		logic       div_step;
		logic       ld_ms;
		logic       inv_sat;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       acc_init;
		logic       acc_add;
		logic       out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sum_hit;
		logic ms_small;
		logic out_free;
	} ctrl_sts_t;

endpackage

`default_nettype wire

[rtl/rmsn_if.sv]
// rmsn_if: valid/ready channel interfaces for input items and results.
// Depends on rmsn_pkg for the payload structs.
`default_nettype none

interface rmsn_item_if;
	import rmsn_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rmsn_result_if;
	import rmsn_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/rms_vector_normalizer.sv]
// rms_vector_normalizer: RMS normalisation of a vector in two passes.
// Items enter on the item channel (op, sample, gain); results leave on the
// result channel (value, saturated, last). Both are valid/ready: a transfer
// happens on a rising edge with valid and ready high.
// An op 0 item squares the sample into a saturating 64-bit sum and gives
// no result; the block is ready again after its square and accumulate
// steps. The item that completes vector_length samples also forms the
// inverse root: a 65-step mean divide, a 65-step reciprocal divide and a
// 32-step square root on the shared iterative datapath; the inverse
// saturates instead when the mean square plus epsilon is 0 or 1.
// An op 1 item takes four steps on the single 24 x 32 multiplier and
// adder, then the result is written to the output register, after which
// the block takes the next item. A stalled receiver holds the result
// there; the next op 1 item then waits for the register to empty and
// holds back later items; op 0 items and the inverse root before it go on.
// Reset clears the sum, counters, inverse scale (so results read 0 until a
// first accumulate pass) and sets vector_length 4096, epsilon 4295.
// Depends on rmsn_pkg, rmsn_if, rmsn_regs, rmsn_ctrl and rmsn_dp.
`default_nettype none

module rms_vector_normalizer #(
	parameter int MAX_LENGTH = rmsn_pkg::MAX_LENGTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rmsn_pkg::ADDR_W-1:0] paddr,
	input  wire logic [rmsn_pkg::DATA_W-1:0] pwdata,
	output logic      [rmsn_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	rmsn_item_if.sink                        item,
	rmsn_result_if.source                    result
);
	import rmsn_pkg::*;

	cfg_t      cfg;
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;
	logic      item_ready;

	// configuration registers
	rmsn_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	rmsn_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_op    (item.data.op),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	assign item.ready = item_ready;

	// arithmetic and output register
	rmsn_dp #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item_data (item.data),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.out_data  (result.data)
	);

endmodule

`default_nettype wire

[rtl/rmsn_regs.sv]
// rmsn_regs: APB-style configuration registers (vector_length, epsilon).
// Depends on rmsn_pkg.
`default_nettype none

module rmsn_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [rmsn_pkg::ADDR_W-1:0] paddr,
	input  wire logic [rmsn_pkg::DATA_W-1:0] pwdata,
	output logic      [rmsn_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output rmsn_pkg::cfg_t                  cfg
);
	import rmsn_pkg::*;

	logic [VL_W-1:0]  vl_q;
	logic [EPS_W-1:0] eps_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register writes, decoded on the word index bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_q  <= VL_RESET;
			eps_q <= EPS_RESET;
		end else if (wr_en) begin
			case (paddr[ADDR_W-1])
				REG_VL:  vl_q  <= pwdata[VL_W-1:0];
				REG_EPS: eps_q <= pwdata[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[ADDR_W-1])
			REG_VL:  prdata = DATA_W'(vl_q);
			REG_EPS: prdata = DATA_W'(eps_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.vector_length = vl_q;
	assign cfg.epsilon       = eps_q;

endmodule

`default_nettype wire

[rtl/rmsn_ctrl.sv]
// rmsn_ctrl: sequencer for the accumulate, inverse-root and scale passes.
// Drives rmsn_dp through ctrl_cmd_t and reads ctrl_sts_t; depends on rmsn_pkg.
`default_nettype none

module rmsn_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	input  wire logic           item_op,
	output logic                item_ready,
	input  rmsn_pkg::ctrl_sts_t sts,
	output rmsn_pkg::ctrl_cmd_t cmd
);
	import rmsn_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SQR   = 4'd1;
	localparam logic [3:0] ST_ACC   = 4'd2;
	localparam logic [3:0] ST_LDM   = 4'd3;
	localparam logic [3:0] ST_DIVM  = 4'd4;
	localparam logic [3:0] ST_MSADD = 4'd5;
	localparam logic [3:0] ST_MSCHK = 4'd6;
	localparam logic [3:0] ST_DIVR  = 4'd7;
	localparam logic [3:0] ST_SQI   = 4'd8;
	localparam logic [3:0] ST_SQRT  = 4'd9;
	localparam logic [3:0] ST_SG    = 4'd10;
	localparam logic [3:0] ST_PLO   = 4'd11;
	localparam logic [3:0] ST_PHI   = 4'd12;
	localparam logic [3:0] ST_SUM   = 4'd13;
	localparam logic [3:0] ST_OUT   = 4'd14;

	logic [3:0]        state_q, state_d;
	logic [ITER_W-1:0] iter_q, iter_d;

	assign item_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		iter_d  = iter_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = item_op ? ST_SG : ST_SQR;
				end
			end
			ST_SQR: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SQ;
				state_d     = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_sq = 1'b1;
				state_d    = sts.sum_hit ? ST_LDM : ST_IDLE;
			end
			ST_LDM: begin
				cmd.ld_mean = 1'b1;
				iter_d      = ITER_W'(DIV_STEPS - 1);
				state_d     = ST_DIVM;
			end
			ST_DIVM: begin
				cmd.div_step = 1'b1;
				iter_d       = iter_q - 1'b1;
				if (iter_q == '0) begin
					state_d = ST_MSADD;
				end
			end
			ST_MSADD: begin
				cmd.ld_ms = 1'b1;
				state_d   = ST_MSCHK;
			end
			ST_MSCHK: begin
				// mean square of 0 or 1 gives an unrepresentable inverse
				if (sts.ms_small) begin
					cmd.inv_sat = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					iter_d  = ITER_W'(DIV_STEPS - 1);
					state_d = ST_DIVR;
				end
			end
			ST_DIVR: begin
				cmd.div_step = 1'b1;
				iter_d       = iter_q - 1'b1;
				if (iter_q == '0) begin
					state_d = ST_SQI;
				end
			end
			ST_SQI: begin
				cmd.sqrt_init = 1'b1;
				iter_d        = ITER_W'(SQRT_STEPS - 1);
				state_d       = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				iter_d        = iter_q - 1'b1;
				if (iter_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			ST_SG: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SG;
				state_d     = ST_PLO;
			end
			ST_PLO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_LO;
				cmd.hold_hi = 1'b1;
				state_d     = ST_PHI;
			end
			ST_PHI: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_HI;
				cmd.acc_init = 1'b1;
				state_d      = ST_SUM;
			end
			ST_SUM: begin
				cmd.acc_add = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			iter_q  <= iter_d;
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded while output register still occupied");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("ready held high after an input transfer");

	a_end_starts_divide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC && sts.sum_hit) |=> cmd.ld_mean)
		else $error("completed accumulate pass did not start the mean divide");

endmodule

`default_nettype wire

[rtl/rmsn_dp.sv]
// rmsn_dp: datapath with shared multiplier, square sum, restoring divider,
// bit-serial square root, pass counters and output register. Depends on rmsn_pkg.
`default_nettype none

module rmsn_dp #(
	parameter int MAX_LENGTH = rmsn_pkg::MAX_LENGTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  rmsn_pkg::cfg_t       cfg,
	input  rmsn_pkg::in_item_t   item_data,
	input  rmsn_pkg::ctrl_cmd_t  cmd,
	output rmsn_pkg::ctrl_sts_t  sts,
	input  wire logic            out_ready,
	output logic                 out_valid,
	output rmsn_pkg::out_item_t  out_data
);
	import rmsn_pkg::*;

	localparam int CNT_W = $clog2(MAX_LENGTH + 1);
	localparam int CW1   = CNT_W + 1;

	// captured operands
	logic [SAMPLE_W-1:0] smag_q;
	logic [GAIN_W-1:0]   gmag_q;
	logic                neg_q;
	logic [SAMPLE_W-1:0] s_raw;
	logic [GAIN_W-1:0]   g_raw;

	// multiplier
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod_q;
	logic [HI_W-1:0]    sghi_q;

	// accumulate pass
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W:0]   sum_add;
	logic [CNT_W-1:0] sum_cnt_q, scale_cnt_q, len_n;
	logic [CW1-1:0]   sum_inc, scale_inc;

	// divider and root
	logic [DIV_W-1:0]    num_q;
	logic [SUM_W-1:0]    den_q, rem_q;
	logic [DIV_W-1:0]    dv_r, dv_sub;
	logic                dv_ge;
	logic [SUM_W:0]      ms_add;
	logic [SQ_REM_W+1:0] sq_r, sq_t, sq_sub;
	logic                sq_ge;
	logic [INV_W-1:0]    inv_q;
	logic                clip_q;

	// scale result
	logic [ACC_W-1:0]   acc_q;
	logic [MAG_W-1:0]   mag;
	logic [VALUE_W-1:0] val;
	logic               val_clip;
	logic               out_valid_q;
	out_item_t          out_q;

	// effective length: zero acts as one, clamp to the maximum
	always_comb begin
		if (cfg.vector_length == '0) begin
			len_n = CNT_W'(1);
		end else if (32'(cfg.vector_length) > 32'(MAX_LENGTH)) begin
			len_n = CNT_W'(MAX_LENGTH);
		end else begin
			len_n = CNT_W'(cfg.vector_length);
		end
	end

	assign sum_inc   = CW1'(sum_cnt_q) + CW1'(1);
	assign scale_inc = CW1'(scale_cnt_q) + CW1'(1);

	// input magnitudes and sign of the product
	assign s_raw = item_data.sample;
	assign g_raw = item_data.gain;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			smag_q <= s_raw[SAMPLE_W-1] ? SAMPLE_W'(0) - s_raw : s_raw;
			gmag_q <= g_raw[GAIN_W-1] ? GAIN_W'(0) - g_raw : g_raw;
			neg_q  <= s_raw[SAMPLE_W-1] ^ g_raw[GAIN_W-1];
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		case (cmd.mul_sel)
			MUL_SQ: begin
				mul_a = smag_q;
				mul_b = MUL_B_W'(smag_q);
			end
			MUL_SG: begin
				mul_a = smag_q;
				mul_b = MUL_B_W'(gmag_q);
			end
			MUL_LO: begin
				mul_a = MUL_A_W'(prod_q[LO_W-1:0]);
				mul_b = inv_q;
			end
			MUL_HI: begin
				mul_a = MUL_A_W'(sghi_q);
				mul_b = inv_q;
			end
			default: begin
				mul_a = smag_q;
				mul_b = inv_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		if (cmd.hold_hi) begin
			sghi_q <= prod_q[SG_W-1:LO_W];
		end
	end

	// saturating square sum and pass counters
	assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(prod_q[SQ_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			sum_cnt_q   <= '0;
			scale_cnt_q <= '0;
		end else begin
			if (cmd.acc_sq) begin
				sum_q     <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
				sum_cnt_q <= sum_inc[CNT_W-1:0];
			end else if (cmd.ld_mean) begin
				sum_q     <= '0;
				sum_cnt_q <= '0;
			end
			if (cmd.out_load) begin
				scale_cnt_q <= (scale_inc >= CW1'(len_n)) ? '0 : scale_inc[CNT_W-1:0];
			end
		end
	end

	// restoring divide step: one quotient bit per cycle
	assign dv_r   = {rem_q, num_q[DIV_W-1]};
	assign dv_ge  = dv_r >= {1'b0, den_q};
	assign dv_sub = dv_r - {1'b0, den_q};

	// mean square plus epsilon, saturating
	assign ms_add = {1'b0, num_q[SUM_W-1:0]} + (SUM_W+1)'(cfg.epsilon);

	// restoring square root step: two radicand bits, one root bit per cycle
	assign sq_r   = {rem_q[SQ_REM_W-1:0], num_q[SUM_W-1:SUM_W-2]};
	assign sq_t   = {2'b00, inv_q, 2'b01};
	assign sq_ge  = sq_r >= sq_t;
	assign sq_sub = sq_r - sq_t;

	always_ff @(posedge clk) begin
		if (cmd.ld_mean) begin
			num_q <= {1'b0, sum_q};
			den_q <= SUM_W'(len_n);
			rem_q <= '0;
		end else if (cmd.ld_ms) begin
			// next divide forms 2^64 / ms
			num_q <= {1'b1, {SUM_W{1'b0}}};
			den_q <= ms_add[SUM_W] ? '1 : ms_add[SUM_W-1:0];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[DIV_W-2:0], dv_ge};
			rem_q <= dv_ge ? dv_sub[SUM_W-1:0] : dv_r[SUM_W-1:0];
		end else if (cmd.sqrt_init) begin
			rem_q <= '0;
		end else if (cmd.sqrt_step) begin
			num_q <= {num_q[DIV_W-3:0], 2'b00};
			rem_q <= SUM_W'(sq_ge ? sq_sub : sq_r);
		end
	end

	// inverse scale and its clip flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q  <= '0;
			clip_q <= 1'b0;
		end else if (cmd.inv_sat) begin
			inv_q  <= '1;
			clip_q <= 1'b1;
		end else if (cmd.sqrt_init) begin
			inv_q  <= '0;
			clip_q <= 1'b0;
		end else if (cmd.sqrt_step) begin
			inv_q <= {inv_q[INV_W-2:0], sq_ge};
		end
	end

	// scale product: low partial plus half an LSB, then high partial
	always_ff @(posedge clk) begin
		if (cmd.acc_init) begin
			acc_q <= ACC_W'(prod_q) + ROUND_HALF;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + (ACC_W'(prod_q) << LO_W);
		end
	end

	// round, saturate and apply sign
	assign mag = acc_q[ACC_W-1:FRAC_SHIFT];

	always_comb begin
		if (neg_q) begin
			val_clip = mag > MAG_W'(VALUE_NEG_MAG);
			val      = VALUE_W'(0) - (val_clip ? VALUE_NEG_MAG : mag[VALUE_W-1:0]);
		end else begin
			val_clip = mag > MAG_W'(VALUE_POS_MAX);
			val      = val_clip ? VALUE_POS_MAX : mag[VALUE_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.value     <= val;
			out_q.saturated <= val_clip || clip_q;
			out_q.last      <= scale_inc >= CW1'(len_n);
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_q;
	assign sts.sum_hit  = sum_inc >= CW1'(len_n);
	assign sts.ms_small = (den_q[SUM_W-1:1] == '0);
	assign sts.out_free = !out_valid_q || out_ready;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (den_q != '0))
		else $error("divide step with a zero divisor");

endmodule

`default_nettype wire

[dv/tb_rms_vector_normalizer.sv]
// Self-checking testbench for rms_vector_normalizer: random and directed
// accumulate/scale passes against a fixed-point predictor, under idling and stalls.
// Depends on rmsn_pkg, rmsn_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_rms_vector_normalizer;
	import rmsn_pkg::*;

	// item operations
	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_SCALE = 1'b1;

	// register byte addresses
	localparam logic [ADDR_W-1:0] ADDR_VL  = {REG_VL, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_EPS = {REG_EPS, 2'b00};

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [GAIN_W-1:0]   GAIN_MAX   = {1'b0, {(GAIN_W-1){1'b1}}};
	localparam logic signed [GAIN_W-1:0]   GAIN_MIN   = {1'b1, {(GAIN_W-1){1'b0}}};
	localparam logic signed [GAIN_W-1:0]   GAIN_ONE   = 16'sd4096;

	localparam int SETTLE_CYCLES = 300;	// covers the inverse root after the last transfer
	localparam int DRAIN_LIMIT   = 20000;
	localparam int PHASE_ITEMS   = 90;
	localparam int CLAMP_ITEMS   = 48;	// elements per pass at the clamped length

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	rmsn_item_if   item_ch ();
	rmsn_result_if result_ch ();

	rms_vector_normalizer i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.result  (result_ch)
	);

	always #10 clk = ~clk;

	// register copies and predictor state
	logic [VL_W-1:0]  vl_setting  = VL_RESET;
	logic [EPS_W-1:0] eps_setting = EPS_RESET;
	logic [SUM_W-1:0] sq_sum      = '0;
	logic [INV_W-1:0] inv_scale   = '0;
	logic             inv_clipped = 1'b0;
	int unsigned      acc_count   = 0;
	int unsigned      scl_count   = 0;

	in_item_t  item_backlog[$];
	out_item_t expected_results[$];

	int unsigned item_gap_pct = 0;
	int unsigned stall_pct    = 0;
	int unsigned failures     = 0;
	int unsigned items_queued = 0;
	int unsigned accum_seen   = 0;
	int unsigned scale_seen   = 0;
	int unsigned roots_formed = 0;
	int unsigned roots_clipped = 0;
	int unsigned results_checked = 0;
	int unsigned reg_writes   = 0;

	function automatic int unsigned vector_len();
		if (vl_setting == '0)
			return 1;
		if (vl_setting > MAX_LENGTH_DEF)
			return MAX_LENGTH_DEF;
		return vl_setting;
	endfunction

	// largest q with q*q*ms <= 2^64, i.e. floor(2^32 / sqrt(ms))
	function automatic logic [INV_W-1:0] inverse_root(input logic [SUM_W-1:0] ms);
		logic [INV_W-1:0] q;
		logic [INV_W-1:0] c;
		logic [127:0]     p;
		q = '0;
		for (int b = INV_W - 1; b >= 0; b--) begin
			c = q | (32'd1 << b);
			p = 128'(c) * 128'(c) * 128'(ms);
			if (p <= (128'd1 << 64))
				q = c;
		end
		return q;
	endfunction

	// accumulate pass: square into the saturating sum, form the inverse at length
	function automatic void absorb_square(input logic signed [SAMPLE_W-1:0] s);
		logic [SAMPLE_W-1:0] smag;
		logic [SUM_W:0]      acc;
		logic [SUM_W-1:0]    mean;
		logic [SUM_W:0]      ms_wide;
		logic [SUM_W-1:0]    ms;
		int unsigned         n;
		n = vector_len();
		smag = s[SAMPLE_W-1] ? (~s + 1'b1) : s;
		acc = {1'b0, sq_sum} + 65'(smag) * 65'(smag);
		sq_sum = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
		acc_count++;
		if (acc_count >= n) begin
			mean = sq_sum / 64'(n);
			ms_wide = {1'b0, mean} + 65'(eps_setting);
			ms = ms_wide[SUM_W] ? '1 : ms_wide[SUM_W-1:0];
			if (ms <= 64'd1) begin
				inv_scale = '1;
				inv_clipped = 1'b1;
				roots_clipped++;
			end else begin
				inv_scale = inverse_root(ms);
				inv_clipped = 1'b0;
			end
			roots_formed++;
			sq_sum = '0;
			acc_count = 0;
		end
	endfunction

	// scale pass: gain * sample * inverse, rounded half away from zero, saturated
	function automatic out_item_t scale_element(input logic signed [SAMPLE_W-1:0] s,
			input logic signed [GAIN_W-1:0] g);
		out_item_t           r;
		logic [SAMPLE_W-1:0] smag;
		logic [GAIN_W-1:0]   gmag;
		logic                neg;
		logic                clip;
		logic [38:0]         sg;
		logic [70:0]         prod;
		logic [71:0]         rounded;
		logic [43:0]         mag;
		int unsigned         n;
		n = vector_len();
		smag = s[SAMPLE_W-1] ? (~s + 1'b1) : s;
		gmag = g[GAIN_W-1] ? (~g + 1'b1) : g;
		neg = s[SAMPLE_W-1] ^ g[GAIN_W-1];
		sg = 39'(smag) * 39'(gmag);
		prod = 71'(sg) * 71'(inv_scale);
		rounded = 72'(prod) + (72'd1 << 27);
		mag = 44'(rounded >> 28);
		clip = 1'b0;
		if (neg) begin
			if (mag > 44'd8388608) begin
				mag = 44'd8388608;
				clip = 1'b1;
			end
			r.value = ~mag[VALUE_W-1:0] + 1'b1;
		end else begin
			if (mag > 44'd8388607) begin
				mag = 44'd8388607;
				clip = 1'b1;
			end
			r.value = mag[VALUE_W-1:0];
		end
		scl_count++;
		r.last = 1'b0;
		if (scl_count >= n) begin
			r.last = 1'b1;
			scl_count = 0;
		end
		r.saturated = clip | inv_clipped;
		return r;
	endfunction

	// item driver: next pending item, with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || item_ch.ready) begin
			if (item_backlog.size() != 0 && $urandom_range(99) >= item_gap_pct) begin
				item_ch.data  <= item_backlog.pop_front();
				item_ch.valid <= 1'b1;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver stalls
	always @(posedge clk) begin
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// input monitor: every accepted item goes through the predictor
	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready) begin
			if (item_ch.data.op == OP_SCALE) begin
				expected_results.push_back(scale_element(item_ch.data.sample,
					item_ch.data.gain));
				scale_seen++;
			end else begin
				absorb_square(item_ch.data.sample);
				accum_seen++;
			end
		end
	end

	// result monitor: compare each transfer with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (expected_results.size() == 0) begin
				$error("unexpected result: value %0d saturated %0b last %0b",
					got.value, got.saturated, got.last);
				failures++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (got.value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, got.value);
					failures++;
				end
				if (got.saturated !== want.saturated) begin
					$error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
					failures++;
				end
				if (got.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, got.last);
					failures++;
				end
			end
		end
	end

	task automatic queue_item(input logic op, input logic signed [SAMPLE_W-1:0] s,
			input logic signed [GAIN_W-1:0] g);
		item_backlog.push_back('{op, s, g});
		items_queued++;
	endtask

	// wait for the sender to empty, all results back, then the block's own tail
	task automatic settle();
		int unsigned waited;
		waited = 0;
		while (item_backlog.size() != 0 || item_ch.valid)
			@(posedge clk);
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			failures++;
			expected_results.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_VL)
			vl_setting = data[VL_W-1:0];
		else
			eps_setting = data[EPS_W-1:0];
		reg_writes++;
	endtask

	task automatic check_register(input logic [ADDR_W-1:0] addr);
		logic [DATA_W-1:0] want;
		want = (addr == ADDR_VL) ? DATA_W'(vl_setting) : DATA_W'(eps_setting);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (prdata !== want) begin
			$error("prdata at %0d: expected %0d, got %0d", addr, want, prdata);
			failures++;
		end
	endtask

	task automatic configure(input logic [VL_W-1:0] vl, input logic [EPS_W-1:0] eps);
		set_register(ADDR_VL, DATA_W'(vl));
		set_register(ADDR_EPS, eps);
		check_register(ADDR_VL);
		check_register(ADDR_EPS);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(3))
			0: return SAMPLE_W'($urandom);
			1: return $signed(SAMPLE_W'($urandom)) >>> $urandom_range(22);
			2: begin
				case ($urandom_range(3))
					0: return SAMPLE_MAX;
					1: return SAMPLE_MIN;
					2: return '0;
					default: return -24'sd1;
				endcase
			end
			default: return $signed(SAMPLE_W'($urandom)) >>> $urandom_range(8, 16);
		endcase
	endfunction

	function automatic logic signed [GAIN_W-1:0] rand_gain();
		case ($urandom_range(5))
			0: return GAIN_ONE;
			1: return $urandom_range(1) ? GAIN_MAX : GAIN_MIN;
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	// mostly a full vector over both passes; sometimes noise or a cut-short pass
	task automatic add_sequence();
		logic signed [SAMPLE_W-1:0] elems[$];
		int unsigned n;
		int unsigned k;
		n = vector_len();
		case ($urandom_range(9))
			8: begin
				k = $urandom_range(1, 2 * n);
				repeat (k) queue_item($urandom_range(1) ? OP_SCALE : OP_ACCUM,
					rand_sample(), rand_gain());
			end
			9: begin
				k = $urandom_range(0, n - 1);
				repeat (k) queue_item(OP_ACCUM, rand_sample(), rand_gain());
				repeat ($urandom_range(1, n)) queue_item(OP_SCALE, rand_sample(), rand_gain());
			end
			default: begin
				repeat (n) elems.push_back(rand_sample());
				foreach (elems[i]) queue_item(OP_ACCUM, elems[i], rand_gain());
				foreach (elems[i]) queue_item(OP_SCALE, elems[i], rand_gain());
			end
		endcase
	endtask

	function automatic logic [VL_W-1:0] pick_length();
		case ($urandom_range(7))
			0: return '0;
			1: return 13'd1;
			default: return VL_W'($urandom_range(2, 16));
		endcase
	endfunction

	function automatic logic [EPS_W-1:0] pick_epsilon();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	// stimulus
	initial begin
		logic signed [SAMPLE_W-1:0] big_vec[$];
		int unsigned target;
		bit paused;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset values read back
		check_register(ADDR_VL);
		check_register(ADDR_EPS);

		// scale before any accumulate: inverse still zero
		queue_item(OP_SCALE, SAMPLE_MAX, GAIN_MAX);
		queue_item(OP_SCALE, SAMPLE_MIN, GAIN_MIN);
		settle();

		// length 0 acts as 1; zero mean square clips the inverse
		configure('0, '0);
		queue_item(OP_ACCUM, '0, GAIN_MAX);
		queue_item(OP_SCALE, SAMPLE_MAX, GAIN_MAX);
		queue_item(OP_SCALE, SAMPLE_MIN, GAIN_MAX);
		queue_item(OP_SCALE, 24'sd1, 16'sd1);
		queue_item(OP_SCALE, '0, GAIN_MIN);
		// full-scale negative sample gives an exact inverse
		queue_item(OP_ACCUM, SAMPLE_MIN, '0);
		queue_item(OP_SCALE, SAMPLE_MIN, GAIN_MIN);
		queue_item(OP_SCALE, SAMPLE_MAX, GAIN_ONE);
		queue_item(OP_SCALE, SAMPLE_MIN, GAIN_ONE);
		settle();

		// mean square of exactly one still clips, two does not
		configure(13'd1, 32'd1);
		queue_item(OP_ACCUM, '0, '0);
		queue_item(OP_SCALE, SAMPLE_MAX, GAIN_ONE);
		settle();
		configure(13'd1, 32'd2);
		queue_item(OP_ACCUM, '0, '0);
		queue_item(OP_SCALE, 24'sd1, GAIN_ONE);
		settle();

		// largest epsilon
		configure(13'd1, '1);
		queue_item(OP_ACCUM, SAMPLE_MAX, '0);
		queue_item(OP_SCALE, SAMPLE_MAX, GAIN_MAX);
		settle();

		// length shortened part way through both passes
		configure(13'd4, EPS_RESET);
		queue_item(OP_ACCUM, rand_sample(), '0);
		queue_item(OP_ACCUM, rand_sample(), '0);
		queue_item(OP_SCALE, rand_sample(), rand_gain());
		settle();
		configure(13'd2, EPS_RESET);
		queue_item(OP_ACCUM, rand_sample(), '0);
		queue_item(OP_SCALE, rand_sample(), GAIN_ONE);
		queue_item(OP_SCALE, rand_sample(), GAIN_ONE);
		settle();

		// part of a vector at the largest length, clamped from the top register value;
		// the next shorter length then ends both passes early
		configure('1, EPS_RESET);
		repeat (CLAMP_ITEMS) big_vec.push_back($urandom_range(1) ? SAMPLE_MIN : rand_sample());
		foreach (big_vec[i]) queue_item(OP_ACCUM, big_vec[i], rand_gain());
		foreach (big_vec[i]) queue_item(OP_SCALE, big_vec[i], rand_gain());
		settle();

		// random vectors under four idling mixes
		paused = 1'b0;
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			configure(pick_length(), pick_epsilon());
			case (ph)
				0: begin item_gap_pct = 0;  stall_pct = 0;  end
				1: begin item_gap_pct = 56; stall_pct = 0;  end
				2: begin item_gap_pct = 0;  stall_pct = 56; end
				default: begin item_gap_pct = 31; stall_pct = 31; end
			endcase
			target = items_queued + PHASE_ITEMS;
			while (items_queued < target) begin
				add_sequence();
				// sender holds off until every result is back
				if (ph == 2 && !paused && items_queued + PHASE_ITEMS / 2 >= target) begin
					settle();
					paused = 1'b1;
				end
			end
		end
		settle();

		$display("Covered %0d accumulate and %0d scale transfers, %0d inverse roots (%0d clipped),",
			accum_seen, scale_seen, roots_formed, roots_clipped);
		$display("%0d results checked, %0d register writes, four idle/stall mixes.",
			results_checked, reg_writes);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
